/* hdl/vna_pkg.sv */
// Shared types, codes and a helper function of the vertex normal accumulator.
package vna_pkg;

  // Command codes carried by the command field.
  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_ADD   = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // Status codes of a read result.
  localparam logic [1:0] STAT_OK         = 2'd0;
  localparam logic [1:0] STAT_NOT_LOADED = 2'd1;
  localparam logic [1:0] STAT_OVERFLOW   = 2'd2;

  // Magnitudes are normalized into [2^29, 2^30) before the square root.
  localparam int unsigned NORM_BITS = 30;
  localparam int unsigned QUO_BITS  = 18;

  // Handshake between the sequencer and the normalizer.
  typedef struct packed {
    logic start;
  } norm_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } norm_rsp_t;

  // Apply the sign to an unsigned quotient and clamp to the Q1.15 range.
  function automatic logic signed [15:0] apply_sign(input logic [QUO_BITS-1:0] q,
                                                    input logic neg);
    logic signed [15:0] r;
    if (neg) begin
      if (q > QUO_BITS'(32768)) r = -16'sd32768;
      else r = 16'(-$signed({1'b0, q}));
    end else begin
      if (q > QUO_BITS'(32767)) r = 16'sd32767;
      else r = 16'(q);
    end
    return r;
  endfunction

endpackage

/* hdl/vna_if.sv */
// Valid/ready channel interfaces for input items and result items.
interface vna_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [15:0] face_nx;
  logic signed [15:0] face_ny;
  logic signed [15:0] face_nz;
  logic [11:0]        vertex_number;

  modport source (output valid, command, pos_x, pos_y, pos_z, face_nx, face_ny, face_nz,
                  vertex_number, input ready);
  modport sink (input valid, command, pos_x, pos_y, pos_z, face_nx, face_ny, face_nz,
                vertex_number, output ready);
endinterface

interface vna_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] normal_x;
  logic signed [15:0] normal_y;
  logic signed [15:0] normal_z;
  logic [1:0]         status;

  modport source (output valid, normal_x, normal_y, normal_z, status, input ready);
  modport sink (input valid, normal_x, normal_y, normal_z, status, output ready);
endinterface

/* hdl/vna_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
module vna_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* hdl/vna_norm.sv */
// Iterative unit that scales a summed normal to unit length in Q1.15.
module vna_norm #(
  parameter int unsigned SUM_BITS = 28
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  vna_pkg::norm_req_t         req_i,
  input  logic signed [SUM_BITS-1:0] sum_x_i,
  input  logic signed [SUM_BITS-1:0] sum_y_i,
  input  logic signed [SUM_BITS-1:0] sum_z_i,
  output vna_pkg::norm_rsp_t         rsp_o,
  output logic signed [15:0]         norm_x_o,
  output logic signed [15:0]         norm_y_o,
  output logic signed [15:0]         norm_z_o
);

  localparam int unsigned NB = vna_pkg::NORM_BITS;
  localparam int unsigned MW = (SUM_BITS > NB) ? SUM_BITS : NB;
  localparam int unsigned QB = vna_pkg::QUO_BITS;
  localparam int unsigned NUMW = NB + 17;

  typedef enum logic [2:0] {
    N_IDLE, N_SHIFT, N_MUL, N_ACC, N_SQRT, N_DINIT, N_DIV, N_DONE
  } nstate_e;

  nstate_e              state_q;
  logic [MW-1:0]        m_q [3];
  logic [2:0]           neg_q;
  logic [2*NB-1:0]      prod_q;
  logic [63:0]          n_q, r_q, bit_q;
  logic [1:0]           idx_q;
  logic [4:0]           cnt_q;
  logic [NUMW-1:0]      num_q;
  logic [31:0]          rem_q;
  logic [QB-1:0]        quo_q;
  logic signed [15:0]   res_q [3];

  logic [SUM_BITS-1:0]  mag [3];
  logic signed [SUM_BITS-1:0] sums [3];
  logic [MW-1:0]        mx, msel;
  logic [63:0]          trial;
  logic [31:0]          dvs;
  logic [NUMW-1:0]      num_d;
  logic [32:0]          shl;
  logic                 qbit;
  logic [QB-1:0]        quo_d;

  // Magnitudes of the incoming sums.
  always_comb begin
    sums[0] = sum_x_i;
    sums[1] = sum_y_i;
    sums[2] = sum_z_i;
    for (int i = 0; i < 3; i++) begin
      mag[i] = sums[i][SUM_BITS-1] ? SUM_BITS'(-sums[i]) : SUM_BITS'(sums[i]);
    end
  end

  // Shared datapath: largest magnitude, square root trial, division step.
  always_comb begin
    mx = m_q[0];
    if (m_q[1] > mx) mx = m_q[1];
    if (m_q[2] > mx) mx = m_q[2];
    msel  = m_q[idx_q];
    trial = r_q + bit_q;
    dvs   = {r_q[30:0], 1'b0};
    num_d = NUMW'({msel[NB-1:0], 16'b0}) + NUMW'(r_q[31:0]);
    shl   = {rem_q, num_q[cnt_q]};
    qbit  = (shl >= {1'b0, dvs});
    quo_d = {quo_q[QB-2:0], qbit};
  end

  // Sequencer and datapath registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= N_IDLE;
      idx_q   <= '0;
      cnt_q   <= '0;
    end else begin
      unique case (state_q)
        N_IDLE: begin
          if (req_i.start) begin
            for (int i = 0; i < 3; i++) begin
              m_q[i]   <= MW'(mag[i]);
              neg_q[i] <= sums[i][SUM_BITS-1];
              res_q[i] <= '0;
            end
            n_q   <= '0;
            idx_q <= '0;
            if (mag[0] == '0 && mag[1] == '0 && mag[2] == '0) state_q <= N_DONE;
            else state_q <= N_SHIFT;
          end
        end
        N_SHIFT: begin
          if ((mx >> NB) != '0) begin
            for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] >> 1;
          end else if ((mx >> (NB - 1)) == '0) begin
            for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] << 1;
          end else begin
            state_q <= N_MUL;
          end
        end
        N_MUL: begin
          prod_q  <= msel[NB-1:0] * msel[NB-1:0];
          state_q <= N_ACC;
        end
        N_ACC: begin
          n_q <= n_q + 64'(prod_q);
          if (idx_q == 2'd2) begin
            r_q     <= '0;
            bit_q   <= 64'h4000_0000_0000_0000;
            state_q <= N_SQRT;
          end else begin
            idx_q   <= idx_q + 2'd1;
            state_q <= N_MUL;
          end
        end
        N_SQRT: begin
          if (n_q >= trial) begin
            n_q <= n_q - trial;
            r_q <= (r_q >> 1) + bit_q;
          end else begin
            r_q <= r_q >> 1;
          end
          bit_q <= bit_q >> 2;
          if (bit_q == 64'd1) begin
            idx_q   <= '0;
            state_q <= N_DINIT;
          end
        end
        N_DINIT: begin
          num_q   <= num_d;
          rem_q   <= 32'(num_d >> QB);
          quo_q   <= '0;
          cnt_q   <= 5'(QB - 1);
          state_q <= N_DIV;
        end
        N_DIV: begin
          rem_q <= qbit ? 32'(shl - {1'b0, dvs}) : shl[31:0];
          quo_q <= quo_d;
          cnt_q <= cnt_q - 5'd1;
          if (cnt_q == '0) begin
            res_q[idx_q] <= vna_pkg::apply_sign(quo_d, neg_q[idx_q]);
            if (idx_q == 2'd2) begin
              state_q <= N_DONE;
            end else begin
              idx_q   <= idx_q + 2'd1;
              state_q <= N_DINIT;
            end
          end
        end
        N_DONE: state_q <= N_IDLE;
        default: state_q <= N_IDLE;
      endcase
    end
  end

  assign rsp_o.busy = (state_q != N_IDLE);
  assign rsp_o.done = (state_q == N_DONE);
  assign norm_x_o = res_q[0];
  assign norm_y_o = res_q[1];
  assign norm_z_o = res_q[2];

  // The square root ends with a root below 2^31, so the divisor fits 32 bits.
  a_root_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == N_DINIT) |-> (r_q[63:31] == '0))
    else $error("square root out of range");

  // The partial remainder always stays below the divisor.
  a_rem_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == N_DIV) |-> (rem_q < dvs))
    else $error("division remainder not below divisor");

  // A start is only taken while the unit is free.
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> (state_q == N_IDLE))
    else $error("normalizer started while busy");

endmodule

/* hdl/vertex_normal_accumulator_top.sv */
// Top level of the vertex normal accumulator: position table, sums and sequencer.
//
// Input items arrive on in_i (valid/ready). A clear command empties the table
// as it is accepted. An add command searches the position table one entry at a
// time, reading each key in S_SRCH_RD and comparing it in S_SRCH_CMP. A new
// position is appended, and the face normal is added to the entry's saturating
// sum. A read command for a loaded vertex gives one result on out_o: a map read,
// a sum read and the iterative normalizer, which shifts one bit per cycle,
// squares three terms, runs a 32-step square root and three divisions; a read
// of an unloaded vertex skips them and gives STAT_NOT_LOADED. in_i.ready is high
// only while the sequencer is idle. A finished result sits in the output
// register; the sequencer takes a new item while it waits, and a read that
// finishes before it is taken holds until out_o.ready. Reset clears the
// counters and the overflow flag at once; the memories need no clearing pass.
module vertex_normal_accumulator_top #(
  parameter int unsigned MAX_UNIQUE_POSITIONS = 1024,
  parameter int unsigned MAX_VERTICES         = 4096,
  parameter int unsigned SUM_BITS             = 28
) (
  input  logic clk_i,
  input  logic rst_ni,
  vna_in_if.sink    in_i,
  vna_out_if.source out_o
);

  localparam int unsigned EW = $clog2(MAX_UNIQUE_POSITIONS);
  localparam int unsigned UW = $clog2(MAX_UNIQUE_POSITIONS + 1);
  localparam int unsigned VW = $clog2(MAX_VERTICES);
  localparam int unsigned LW = $clog2(MAX_VERTICES + 1);
  localparam int unsigned CW = (LW > 12) ? LW : 12;

  typedef enum logic [3:0] {
    S_IDLE, S_SRCH_RD, S_SRCH_CMP, S_SUM_ADD, S_MAP_WAIT, S_SUM_WAIT,
    S_NORM_START, S_NORM_WAIT, S_FINISH
  } state_e;

  state_e state_q;
  logic [UW-1:0] used_q;
  logic [LW-1:0] loaded_q;
  logic          ovf_q;
  logic [UW-1:0] e_q;

  // Latched input item.
  logic [95:0]                key_q;
  logic signed [15:0]         fn_q [3];
  logic [CW-1:0]              vn_q;

  // Output register.
  logic                       out_valid_q;
  logic signed [15:0]         out_n_q [3];
  logic [1:0]                 out_stat_q;
  logic signed [15:0]         res_n_q [3];
  logic [1:0]                 res_stat_q;

  // Memory ports.
  logic                       key_we, key_re, sum_we, sum_re, map_we, map_re;
  logic [EW-1:0]              key_waddr, key_raddr, sum_waddr, sum_raddr;
  logic [95:0]                key_wdata, key_rdata;
  logic [3*SUM_BITS-1:0]      sum_wdata, sum_rdata;
  logic [VW-1:0]              map_waddr, map_raddr;
  logic [EW-1:0]              map_wdata, map_rdata;

  vna_pkg::norm_req_t         nreq;
  vna_pkg::norm_rsp_t         nrsp;
  logic signed [15:0]         nx, ny, nz;

  logic signed [SUM_BITS-1:0] old_s [3];
  logic signed [SUM_BITS-1:0] new_s [3];
  logic signed [SUM_BITS:0]   wide_s;
  logic                       accept, out_free;

  assign accept   = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;

  // Saturating addition of the face normal to the stored sums.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      old_s[i] = sum_rdata[i*SUM_BITS +: SUM_BITS];
      wide_s   = (SUM_BITS + 1)'(old_s[i]) + (SUM_BITS + 1)'(fn_q[i]);
      if (wide_s[SUM_BITS] != wide_s[SUM_BITS-1]) begin
        new_s[i] = wide_s[SUM_BITS] ? {1'b1, {(SUM_BITS - 1){1'b0}}}
                                    : {1'b0, {(SUM_BITS - 1){1'b1}}};
      end else begin
        new_s[i] = wide_s[SUM_BITS-1:0];
      end
    end
  end

  // Memory port control from the sequencer state.
  always_comb begin
    key_we    = 1'b0;
    key_re    = 1'b0;
    sum_we    = 1'b0;
    sum_re    = 1'b0;
    map_we    = 1'b0;
    map_re    = 1'b0;
    key_waddr = e_q[EW-1:0];
    key_raddr = e_q[EW-1:0];
    key_wdata = key_q;
    sum_waddr = e_q[EW-1:0];
    sum_raddr = e_q[EW-1:0];
    sum_wdata = {SUM_BITS'(fn_q[2]), SUM_BITS'(fn_q[1]), SUM_BITS'(fn_q[0])};
    map_waddr = loaded_q[VW-1:0];
    map_wdata = e_q[EW-1:0];
    map_raddr = vn_q[VW-1:0];
    nreq.start = 1'b0;
    unique case (state_q)
      S_SRCH_RD: begin
        if (e_q == used_q) begin
          if (used_q != UW'(MAX_UNIQUE_POSITIONS)) begin
            key_we = 1'b1;
            sum_we = 1'b1;
            map_we = 1'b1;
          end
        end else begin
          key_re = 1'b1;
        end
      end
      S_SRCH_CMP: begin
        sum_re = (key_rdata == key_q);
      end
      S_SUM_ADD: begin
        sum_we    = 1'b1;
        sum_wdata = {new_s[2], new_s[1], new_s[0]};
        map_we    = 1'b1;
      end
      S_MAP_WAIT: begin
        sum_re    = 1'b1;
        sum_raddr = map_rdata;
      end
      S_NORM_START: nreq.start = 1'b1;
      default: ;
    endcase
    if (state_q == S_IDLE && accept && in_i.command == vna_pkg::CMD_READ) begin
      map_re = 1'b1;
      map_raddr = VW'(in_i.vertex_number);
    end
  end

  // Sequencer, counters and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      used_q      <= '0;
      loaded_q    <= '0;
      ovf_q       <= 1'b0;
      e_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_o.ready) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            key_q    <= {in_i.pos_z, in_i.pos_y, in_i.pos_x};
            fn_q[0]  <= in_i.face_nx;
            fn_q[1]  <= in_i.face_ny;
            fn_q[2]  <= in_i.face_nz;
            vn_q     <= CW'(in_i.vertex_number);
            e_q      <= '0;
            unique case (in_i.command)
              vna_pkg::CMD_CLEAR: begin
                used_q   <= '0;
                loaded_q <= '0;
                ovf_q    <= 1'b0;
              end
              vna_pkg::CMD_ADD: begin
                if (loaded_q == LW'(MAX_VERTICES)) ovf_q <= 1'b1;
                else state_q <= S_SRCH_RD;
              end
              vna_pkg::CMD_READ: begin
                if (CW'(in_i.vertex_number) >= CW'(loaded_q)) begin
                  for (int i = 0; i < 3; i++) res_n_q[i] <= '0;
                  res_stat_q <= vna_pkg::STAT_NOT_LOADED;
                  state_q    <= S_FINISH;
                end else begin
                  state_q <= S_MAP_WAIT;
                end
              end
              default: ;
            endcase
          end
        end
        S_SRCH_RD: begin
          if (e_q == used_q) begin
            if (used_q == UW'(MAX_UNIQUE_POSITIONS)) begin
              ovf_q <= 1'b1;
            end else begin
              used_q   <= used_q + UW'(1);
              loaded_q <= loaded_q + LW'(1);
            end
            state_q <= S_IDLE;
          end else begin
            state_q <= S_SRCH_CMP;
          end
        end
        S_SRCH_CMP: begin
          if (key_rdata == key_q) begin
            state_q <= S_SUM_ADD;
          end else begin
            e_q     <= e_q + UW'(1);
            state_q <= S_SRCH_RD;
          end
        end
        S_SUM_ADD: begin
          loaded_q <= loaded_q + LW'(1);
          state_q  <= S_IDLE;
        end
        S_MAP_WAIT:   state_q <= S_SUM_WAIT;
        S_SUM_WAIT:   state_q <= S_NORM_START;
        S_NORM_START: state_q <= S_NORM_WAIT;
        S_NORM_WAIT: begin
          if (nrsp.done) begin
            res_n_q[0] <= nx;
            res_n_q[1] <= ny;
            res_n_q[2] <= nz;
            res_stat_q <= ovf_q ? vna_pkg::STAT_OVERFLOW : vna_pkg::STAT_OK;
            state_q    <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_n_q     <= res_n_q;
            out_stat_q  <= res_stat_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_i.ready     = (state_q == S_IDLE);
  assign out_o.valid    = out_valid_q;
  assign out_o.normal_x = out_n_q[0];
  assign out_o.normal_y = out_n_q[1];
  assign out_o.normal_z = out_n_q[2];
  assign out_o.status   = out_stat_q;

  // Position keys, sums and the vertex to entry map.
  vna_ram #(.WIDTH(96), .DEPTH(MAX_UNIQUE_POSITIONS)) u_key_ram (
    .clk_i, .wr_en_i(key_we), .wr_addr_i(key_waddr), .wr_data_i(key_wdata),
    .rd_en_i(key_re), .rd_addr_i(key_raddr), .rd_data_o(key_rdata)
  );

  vna_ram #(.WIDTH(3 * SUM_BITS), .DEPTH(MAX_UNIQUE_POSITIONS)) u_sum_ram (
    .clk_i, .wr_en_i(sum_we), .wr_addr_i(sum_waddr), .wr_data_i(sum_wdata),
    .rd_en_i(sum_re), .rd_addr_i(sum_raddr), .rd_data_o(sum_rdata)
  );

  vna_ram #(.WIDTH(EW), .DEPTH(MAX_VERTICES)) u_map_ram (
    .clk_i, .wr_en_i(map_we), .wr_addr_i(map_waddr), .wr_data_i(map_wdata),
    .rd_en_i(map_re), .rd_addr_i(map_raddr), .rd_data_o(map_rdata)
  );

  vna_norm #(.SUM_BITS(SUM_BITS)) u_norm (
    .clk_i, .rst_ni, .req_i(nreq),
    .sum_x_i(sum_rdata[0*SUM_BITS +: SUM_BITS]),
    .sum_y_i(sum_rdata[1*SUM_BITS +: SUM_BITS]),
    .sum_z_i(sum_rdata[2*SUM_BITS +: SUM_BITS]),
    .rsp_o(nrsp), .norm_x_o(nx), .norm_y_o(ny), .norm_z_o(nz)
  );

  // Every table entry is owned by at least one loaded vertex.
  a_used_le_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    LW'(used_q) <= loaded_q || UW > LW)
    else $error("more table entries than loaded vertices");

  // The counters never pass their table sizes.
  a_counter_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= UW'(MAX_UNIQUE_POSITIONS) && loaded_q <= LW'(MAX_VERTICES))
    else $error("table counter out of range");

  // The search index never runs past the filled part of the table.
  a_search_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SRCH_RD || state_q == S_SRCH_CMP) |-> e_q <= used_q)
    else $error("search index beyond filled entries");

  // A new result is loaded only from the finish step.
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_FINISH)
    else $error("result raised outside the finish step");

  // The normalizer stays busy while the sequencer waits on it.
  a_norm_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_NORM_WAIT) |-> nrsp.busy)
    else $error("sequencer waits on an idle normalizer");

endmodule

/* verif/tb_vertex_normal_accumulator_top.sv */
// Self-checking testbench for the vertex normal accumulator top level.
`timescale 1ns / 1ps

module tb_vertex_normal_accumulator_top;

  localparam int unsigned MAX_POS    = 1024;
  localparam int unsigned MAX_VERT   = 4096;
  localparam int unsigned SUM_W      = 28;
  localparam int unsigned IDLE_PCT   = 18;
  localparam int unsigned STALL_LIMIT = 40000;
  localparam int unsigned DRAIN_CYCLES = 300;
  localparam int unsigned RANDOM_ITEMS = 100;

  // The one command code that the block ignores.
  localparam logic [1:0] CMD_NOP = 2'd3;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] face_nx;
    logic signed [15:0] face_ny;
    logic signed [15:0] face_nz;
    logic [11:0]        vertex_number;
  } vertex_req_t;

  typedef struct packed {
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic [1:0]         status;
  } normal_rsp_t;

  logic clk;
  logic rst_n;
  logic no_idle;
  int   mismatches;
  int   stall_cycles;

  vna_in_if  in_if ();
  vna_out_if out_if ();

  vertex_normal_accumulator_top DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Predicted state of the position table and vertex map.
  logic [31:0]              key_x [MAX_POS];
  logic [31:0]              key_y [MAX_POS];
  logic [31:0]              key_z [MAX_POS];
  logic signed [SUM_W-1:0]  sum_x [MAX_POS];
  logic signed [SUM_W-1:0]  sum_y [MAX_POS];
  logic signed [SUM_W-1:0]  sum_z [MAX_POS];
  int unsigned              vert_entry [MAX_VERT];
  int unsigned              n_entries;
  int unsigned              n_verts;
  logic                     ovf_seen;
  normal_rsp_t              expected_normals [$];

  // Clock with a 10 ns period.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [SUM_W-1:0] a,
                                                     input logic signed [15:0] b);
    longint s;
    longint hi;
    hi = (longint'(1) <<< (SUM_W - 1)) - 1;
    s = longint'(a) + longint'(b);
    if (s > hi) s = hi;
    if (s < -hi - 1) s = -hi - 1;
    return s[SUM_W-1:0];
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Scale a summed normal to unit length in Q1.15, rounding half up.
  function automatic normal_rsp_t unit_normal(input logic signed [SUM_W-1:0] s0,
                                              input logic signed [SUM_W-1:0] s1,
                                              input logic signed [SUM_W-1:0] s2);
    longint      sv [3];
    logic [63:0] m [3];
    logic [63:0] mx;
    logic [63:0] d;
    logic [63:0] q;
    logic signed [15:0] o [3];
    normal_rsp_t r;
    sv[0] = s0;
    sv[1] = s1;
    sv[2] = s2;
    for (int i = 0; i < 3; i++) m[i] = (sv[i] < 0) ? -sv[i] : sv[i];
    mx = m[0];
    if (m[1] > mx) mx = m[1];
    if (m[2] > mx) mx = m[2];
    r = '0;
    if (mx == 0) return r;
    while (mx >= (64'd1 << 30)) begin
      mx = mx >> 1;
      for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
    end
    while (mx < (64'd1 << 29)) begin
      mx = mx << 1;
      for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
    end
    d = int_sqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
    for (int i = 0; i < 3; i++) begin
      q = (m[i] * 64'd65536 + d) / (64'd2 * d);
      if (sv[i] < 0) o[i] = (q > 64'd32768) ? -16'sd32768 : 16'(-longint'(q));
      else o[i] = (q > 64'd32767) ? 16'sd32767 : 16'(q);
    end
    r.nx = o[0];
    r.ny = o[1];
    r.nz = o[2];
    return r;
  endfunction

  // Update the predicted table, or predict the read result, for one accepted request.
  task automatic accumulate(input vertex_req_t it);
    int unsigned e;
    normal_rsp_t r;
    case (it.command)
      vna_pkg::CMD_CLEAR: begin
        n_entries = 0;
        n_verts = 0;
        ovf_seen = 1'b0;
      end
      vna_pkg::CMD_ADD: begin
        if (n_verts >= MAX_VERT) begin
          ovf_seen = 1'b1;
        end else begin
          for (e = 0; e < n_entries; e++) begin
            if (key_x[e] == it.pos_x && key_y[e] == it.pos_y && key_z[e] == it.pos_z) break;
          end
          if (e == n_entries && n_entries >= MAX_POS) begin
            ovf_seen = 1'b1;
          end else begin
            if (e == n_entries) begin
              key_x[e] = it.pos_x;
              key_y[e] = it.pos_y;
              key_z[e] = it.pos_z;
              sum_x[e] = '0;
              sum_y[e] = '0;
              sum_z[e] = '0;
              n_entries++;
            end
            sum_x[e] = sat_sum(sum_x[e], it.face_nx);
            sum_y[e] = sat_sum(sum_y[e], it.face_ny);
            sum_z[e] = sat_sum(sum_z[e], it.face_nz);
            vert_entry[n_verts] = e;
            n_verts++;
          end
        end
      end
      vna_pkg::CMD_READ: begin
        if (it.vertex_number >= n_verts) begin
          r = '0;
          r.status = vna_pkg::STAT_NOT_LOADED;
        end else begin
          e = vert_entry[it.vertex_number];
          r = unit_normal(sum_x[e], sum_y[e], sum_z[e]);
          r.status = ovf_seen ? vna_pkg::STAT_OVERFLOW : vna_pkg::STAT_OK;
        end
        expected_normals.push_back(r);
      end
      default: ;
    endcase
  endtask

  // Drive one request; valid stays high across back-to-back requests.
  task automatic send_item(input vertex_req_t it);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      @(negedge clk);
      in_if.valid = 1'b0;
    end
    @(negedge clk);
    in_if.valid         = 1'b1;
    in_if.command       = it.command;
    in_if.pos_x         = it.pos_x;
    in_if.pos_y         = it.pos_y;
    in_if.pos_z         = it.pos_z;
    in_if.face_nx       = it.face_nx;
    in_if.face_ny       = it.face_ny;
    in_if.face_nz       = it.face_nz;
    in_if.vertex_number = it.vertex_number;
    do @(posedge clk); while (!in_if.ready);
    accumulate(it);
  endtask

  function automatic vertex_req_t make_item(input logic [1:0] cmd,
                                            input logic [31:0] px, input logic [31:0] py,
                                            input logic [31:0] pz, input logic [15:0] nx,
                                            input logic [15:0] ny, input logic [15:0] nz,
                                            input logic [11:0] vn);
    vertex_req_t it;
    it.command = cmd;
    it.pos_x = px;
    it.pos_y = py;
    it.pos_z = pz;
    it.face_nx = nx;
    it.face_ny = ny;
    it.face_nz = nz;
    it.vertex_number = vn;
    return it;
  endfunction

  task automatic send_add(input logic [31:0] px, input logic [31:0] py, input logic [31:0] pz,
                          input logic [15:0] nx, input logic [15:0] ny, input logic [15:0] nz);
    send_item(make_item(vna_pkg::CMD_ADD, px, py, pz, nx, ny, nz, 12'($urandom())));
  endtask

  task automatic send_read(input logic [11:0] vn);
    send_item(make_item(vna_pkg::CMD_READ, $urandom(), $urandom(), $urandom(),
                        16'($urandom()), 16'($urandom()), 16'($urandom()), vn));
  endtask

  task automatic send_clear();
    send_item(make_item(vna_pkg::CMD_CLEAR, $urandom(), $urandom(), $urandom(),
                        16'($urandom()), 16'($urandom()), 16'($urandom()),
                        12'($urandom())));
  endtask

  task automatic send_nop(input logic [11:0] vn);
    send_item(make_item(CMD_NOP, $urandom(), $urandom(), $urandom(), 16'($urandom()),
                        16'($urandom()), 16'($urandom()), vn));
  endtask

  // Extremes of positions and normals, zero sums, clear and the unused command.
  task automatic test_directed();
    send_read(12'd0);
    send_read(12'hFFF);
    send_add(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 16'h8000, 16'h8000, 16'h8000);
    send_add(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_add(32'h0, 32'h0, 32'h0, 16'h0001, 16'h0, 16'h0);
    send_add(32'h0, 32'h0, 32'h0, 16'hFFFF, 16'h0, 16'h0);
    send_add(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 16'h0, 16'h7FFF, 16'h0);
    send_add(32'h5, 32'h6, 32'h7, 16'h0, 16'h0, 16'h8000);
    send_read(12'd0);
    send_read(12'd1);
    send_read(12'd2);
    send_read(12'd3);
    send_read(12'd4);
    send_read(12'd5);
    send_read(12'd6);
    send_nop(12'd0);
    send_read(12'd1);
    send_clear();
    send_read(12'd0);
  endtask

  // Fill the position table, then push one new position past its end.
  task automatic test_table_full();
    logic [31:0] py;
    py = $urandom();
    send_clear();
    for (int i = 0; i < MAX_POS; i++) begin
      send_add(i, py, ~i, 16'($urandom()), 16'($urandom()), 16'($urandom()));
    end
    send_read(12'd5);
    send_add(32'hFFFF_0000, py, 32'h1, 16'($urandom()), 16'($urandom()), 16'($urandom()));
    send_add(32'd3, py, ~32'd3, 16'($urandom()), 16'($urandom()), 16'($urandom()));
    send_read(12'd3);
    send_read(12'(MAX_POS));
    send_read(12'(MAX_POS + 1));
    send_clear();
    send_read(12'd0);
  endtask

  // Mostly well-formed meshes over a small pool of positions, with noise.
  task automatic test_random();
    logic [31:0] pool_x [16];
    logic [31:0] pool_y [16];
    logic [31:0] pool_z [16];
    int unsigned k;
    int unsigned pick;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      no_idle = (n >= 30 && n < 70);
      if (n == 0 || n_entries > 40 || $urandom_range(99) < 2) begin
        if (n != 0) send_clear();
        for (int i = 0; i < 16; i++) begin
          pool_x[i] = $urandom();
          pool_y[i] = $urandom();
          pool_z[i] = $urandom();
        end
      end
      pick = $urandom_range(99);
      if (pick < 60) begin
        k = $urandom_range(15);
        send_add(pool_x[k], pool_y[k], pool_z[k], 16'($urandom()), 16'($urandom()),
                 16'($urandom()));
      end else if (pick < 70) begin
        send_add($urandom(), $urandom(), $urandom(), 16'($urandom()), 16'($urandom()),
                 16'($urandom()));
      end else if (pick < 92) begin
        send_read(12'((n_verts > 0) ? $urandom_range(n_verts - 1) : 0));
      end else if (pick < 97) begin
        send_read(12'($urandom()));
      end else begin
        send_nop(12'($urandom()));
      end
    end
    no_idle = 1'b0;
  endtask

  // Result sink: random back-pressure.
  always @(negedge clk) begin
    out_if.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
  end

  // Compare each accepted result with the oldest prediction.
  always @(posedge clk) begin
    normal_rsp_t exp_r;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_normals.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h %h %h status %0d", out_if.normal_x,
                                       out_if.normal_y, out_if.normal_z, out_if.status);
      end else begin
        exp_r = expected_normals.pop_front();
        if (out_if.normal_x !== exp_r.nx || out_if.normal_y !== exp_r.ny ||
            out_if.normal_z !== exp_r.nz || out_if.status !== exp_r.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h %h %h status %0d, got %h %h %h status %0d",
                     exp_r.nx, exp_r.ny, exp_r.nz, exp_r.status, out_if.normal_x,
                     out_if.normal_y, out_if.normal_z, out_if.status);
        end
      end
    end
  end

  // Watchdog on cycles with no handshake on either side.
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst_n = 1'b0;
    no_idle = 1'b0;
    mismatches = 0;
    stall_cycles = 0;
    n_entries = 0;
    n_verts = 0;
    ovf_seen = 1'b0;
    in_if.valid = 1'b0;
    in_if.command = vna_pkg::CMD_CLEAR;
    in_if.pos_x = '0;
    in_if.pos_y = '0;
    in_if.pos_z = '0;
    in_if.face_nx = '0;
    in_if.face_ny = '0;
    in_if.face_nz = '0;
    in_if.vertex_number = '0;
    out_if.ready = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_table_full();
    test_random();

    @(negedge clk);
    in_if.valid = 1'b0;
    while (expected_normals.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_normals.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
